// ===== rtl/core/kaiser_window_coefficient_unit_assert.svh =====
// Assertion macros for the Kaiser window coefficient unit.
// Used by files that include this header; the macros need clk and rst in scope.
`ifndef KAISER_WINDOW_COEFFICIENT_UNIT_ASSERT_SVH
`define KAISER_WINDOW_COEFFICIENT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KWC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("kwc: check failed");
`define KWC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("kwc: reset check failed");
`else
`define KWC_ASSERT(lbl, prop)
`define KWC_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/kwc_pkg.sv =====
// Shared widths, constants and types of the Kaiser window coefficient unit.
// No dependencies; all files but the assertion header use it by scoped names.
`default_nettype none
package kwc_pkg;

  localparam int IDX_W     = 10;
  localparam int LEN_W     = 11;
  localparam int INV_LEN_W = 25;
  localparam int BETA_W    = 24;
  localparam int INV_I0_W  = 41;
  localparam int TERMS_W   = 6;
  localparam int COEF_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 41;

  localparam int MAX_LENGTH_DEF = 1024;
  localparam int MAX_TERMS_DEF  = 32;

  // Front end: |2n-(L-1)| times 1/(L-1) in Q.24.
  localparam int FRAC_W = 24;
  localparam int A_W    = LEN_W + INV_LEN_W;
  // Square root operand (1 - r^2) << 24 and its root.
  localparam int V_W        = 49;
  localparam int ROOT_W     = 25;
  localparam int SQRT_STEPS = 25;
  localparam int X_W        = 24;
  // Series terms in Q.30; (8^k)/k! stays below 512, so 40 bits hold every term.
  localparam int T_W     = 40;
  localparam int T_SHIFT = 20;
  localparam int P_W     = T_W + X_W - T_SHIFT;
  localparam int CHUNK_W = 22;
  localparam int H_SHIFT = 15;
  localparam int H_W     = T_W - H_SHIFT;
  localparam int SUM_W   = 52;
  // Final scaling by 1/I0(beta).
  localparam int PROD_W       = SUM_W + INV_I0_W;
  localparam int RESULT_SHIFT = 47;

  localparam logic [ROOT_W-1:0] ONE_Q24 = ROOT_W'(1) << FRAC_W;
  localparam logic [T_W-1:0]    ONE_T   = T_W'(1) << 30;
  localparam logic [SUM_W-1:0]  ONE_SUM = SUM_W'(1) << 30;
  localparam logic [COEF_W-1:0] COEF_MAX = '1;

  localparam logic [LEN_W-1:0]     RST_WINDOW_LENGTH = LEN_W'(48);
  localparam logic [INV_LEN_W-1:0] RST_INV_LENGTH    = INV_LEN_W'(356962);
  localparam logic [BETA_W-1:0]    RST_BETA          = BETA_W'(8238934);
  localparam logic [INV_I0_W-1:0]  RST_INV_I0        = INV_I0_W'(64'd2940000000);
  localparam logic [TERMS_W-1:0]   RST_TERMS         = TERMS_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 3'd0,
    REG_INV_LENGTH    = 3'd1,
    REG_KAISER_BETA   = 3'd2,
    REG_INV_I0_BETA   = 3'd3,
    REG_SERIES_TERMS  = 3'd4
  } cfg_reg_t;

  // Control that travels with every pipeline word.
  typedef struct packed {
    logic valid;
    logic zero;
  } kwc_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/kwc_front.sv =====
// Front end: window test, distance from the center and (1 - r^2) << 24.
// Depends on kwc_pkg. Two register stages.
`default_nettype none
module kwc_front #(
  parameter int MAX_LENGTH = kwc_pkg::MAX_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [kwc_pkg::IDX_W-1:0]      sample_index,
  input  logic [kwc_pkg::LEN_W-1:0]      window_length,
  input  logic [kwc_pkg::INV_LEN_W-1:0]  inv_length_minus_one,
  output kwc_pkg::kwc_ctl_t              ctl_out,
  output logic [kwc_pkg::V_W-1:0]        v_out
);

  localparam int LEN_CAP = (MAX_LENGTH < (2 ** kwc_pkg::LEN_W)) ? MAX_LENGTH :
                           (2 ** kwc_pkg::LEN_W) - 1;
  localparam logic [kwc_pkg::LEN_W-1:0] LEN_CAP_V = kwc_pkg::LEN_W'(LEN_CAP);

  logic [kwc_pkg::LEN_W-1:0] len, lm1, tw, d;
  logic                      beyond;
  logic [kwc_pkg::A_W-1:0]   a_next;

  kwc_pkg::kwc_ctl_t         s1_ctl;
  logic [kwc_pkg::A_W-1:0]   s1_a;

  logic [2*kwc_pkg::FRAC_W-1:0] sq;
  logic [kwc_pkg::ROOT_W-1:0]   r2, om;
  logic [kwc_pkg::V_W-1:0]      v_next;

  always_comb begin
    len    = (window_length > LEN_CAP_V) ? LEN_CAP_V : window_length;
    beyond = {1'b0, sample_index} >= len;
    lm1    = len - kwc_pkg::LEN_W'(1);
    tw     = {sample_index, 1'b0};
    d      = (tw >= lm1) ? (tw - lm1) : (lm1 - tw);
    a_next = kwc_pkg::A_W'(d) * kwc_pkg::A_W'(inv_length_minus_one);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (en) begin
      s1_ctl <= '{valid: in_valid, zero: beyond};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a <= a_next;
    end
  end

  // r^2 saturates at one once |r| reaches one.
  always_comb begin
    sq = s1_a[kwc_pkg::FRAC_W-1:0] * s1_a[kwc_pkg::FRAC_W-1:0];
    if (|s1_a[kwc_pkg::A_W-1:kwc_pkg::FRAC_W]) begin
      r2 = kwc_pkg::ONE_Q24;
    end else begin
      r2 = {1'b0, sq[2*kwc_pkg::FRAC_W-1:kwc_pkg::FRAC_W]};
    end
    om     = kwc_pkg::ONE_Q24 - r2;
    v_next = {om, {kwc_pkg::FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= v_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kwc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, then root times beta.
// Depends on kwc_pkg. SQRT_STEPS + 1 register stages.
`default_nettype none
module kwc_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  kwc_pkg::kwc_ctl_t           ctl_in,
  input  logic [kwc_pkg::V_W-1:0]     v_in,
  input  logic [kwc_pkg::BETA_W-1:0]  kaiser_beta,
  output kwc_pkg::kwc_ctl_t           ctl_out,
  output logic [kwc_pkg::X_W-1:0]     x_out
);

  localparam int N  = kwc_pkg::SQRT_STEPS;
  localparam int VW = kwc_pkg::V_W;
  localparam int XP_W = kwc_pkg::BETA_W + kwc_pkg::ROOT_W;

  kwc_pkg::kwc_ctl_t ctl_q [N];
  logic [VW-1:0]     rem_q [N];
  logic [VW-1:0]     res_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [VW-1:0] BIT = VW'(1) << (2 * (N - 1 - i));
    kwc_pkg::kwc_ctl_t c_in;
    logic [VW-1:0]     rem_in, res_in, rem_n, res_n;
    logic [VW:0]       trial;

    if (i == 0) begin : g_first
      assign c_in   = ctl_in;
      assign rem_in = v_in;
      assign res_in = '0;
    end else begin : g_next
      assign c_in   = ctl_q[i-1];
      assign rem_in = rem_q[i-1];
      assign res_in = res_q[i-1];
    end

    always_comb begin
      trial = {1'b0, res_in} + {1'b0, BIT};
      if ({1'b0, rem_in} >= trial) begin
        rem_n = rem_in - trial[VW-1:0];
        res_n = (res_in >> 1) + BIT;
      end else begin
        rem_n = rem_in;
        res_n = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[i] <= '0;
      end else if (en) begin
        ctl_q[i] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= rem_n;
        res_q[i] <= res_n;
      end
    end
  end

  logic [XP_W-1:0] xp;
  assign xp = kaiser_beta * res_q[N-1][kwc_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_q[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= xp[kwc_pkg::FRAC_W +: kwc_pkg::X_W];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kwc_term.sv =====
// I0 series term: t_k = ((t * x) >> 20) / (2k); sum += (t_k >> 15)^2 if K <= series_terms.
// Depends on kwc_pkg. Seven register stages; the divide is reciprocal multiply plus fix-up.
`default_nettype none
module kwc_term #(
  parameter int K         = 1,
  parameter int MAX_TERMS = kwc_pkg::MAX_TERMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [kwc_pkg::TERMS_W-1:0]   series_terms,
  input  kwc_pkg::kwc_ctl_t             ctl_in,
  input  logic [kwc_pkg::X_W-1:0]       x_in,
  input  logic [kwc_pkg::T_W-1:0]       t_in,
  input  logic [kwc_pkg::SUM_W-1:0]     sum_in,
  output kwc_pkg::kwc_ctl_t             ctl_out,
  output logic [kwc_pkg::X_W-1:0]       x_out,
  output logic [kwc_pkg::T_W-1:0]       t_out,
  output logic [kwc_pkg::SUM_W-1:0]     sum_out
);

  localparam int CW  = kwc_pkg::CHUNK_W;
  localparam int DIV = 2 * K;
  localparam int R_W = $clog2(2 * MAX_TERMS);
  localparam int Y_W = CW + R_W;
  localparam longint unsigned RECIP_I = (64'd1 << Y_W) / DIV;
  localparam logic [Y_W-1:0]  RECIP   = Y_W'(RECIP_I);
  localparam logic [Y_W-1:0]  D_V     = Y_W'(DIV);
  localparam logic [kwc_pkg::TERMS_W:0] K_V = (kwc_pkg::TERMS_W + 1)'(K);

  typedef struct packed {
    kwc_pkg::kwc_ctl_t          ctl;
    logic [kwc_pkg::X_W-1:0]    x;
    logic [kwc_pkg::SUM_W-1:0]  sum;
  } pass_t;

  pass_t pass_in;
  pass_t s1, s2, s3, s4, s5, s6;
  assign pass_in = '{ctl: ctl_in, x: x_in, sum: sum_in};

  logic [kwc_pkg::T_W+kwc_pkg::X_W-1:0] tx;
  logic [kwc_pkg::P_W-1:0] s1_p;
  logic [Y_W-1:0]          y_hi, y_lo, s2_y, s4_y;
  logic [2*Y_W-1:0]        s2_m, s4_m;
  logic [CW-1:0]           s2_lo, s2_lo_q, s3_q, s4_qhi;
  logic [R_W-1:0]          s3_r;
  logic [Y_W-1:0]          q_hi, r_hi, q_lo, r_lo;
  logic [2*CW-1:0]         t_full;
  logic [kwc_pkg::T_W-1:0] s5_t, s6_t;
  logic [2*kwc_pkg::H_W-1:0] s6_sq;
  logic                    use_term;

  // Quotient estimate is low by at most one; a single compare fixes it.
  function automatic logic [2*Y_W-1:0] fix_div(input logic [Y_W-1:0] y,
                                               input logic [2*Y_W-1:0] m);
    logic [Y_W-1:0] q, qd, r;
    q  = m[Y_W +: Y_W];
    qd = q * D_V;
    r  = y - qd;
    if (r >= D_V) begin
      q = q + Y_W'(1);
      r = r - D_V;
    end
    return {q, r};
  endfunction

  always_comb begin
    tx       = t_in * x_in;
    y_hi     = {{R_W{1'b0}}, s1_p[kwc_pkg::P_W-1:CW]};
    {q_hi, r_hi} = fix_div(s2_y, s2_m);
    y_lo     = {s3_r, s2_lo_q};
    {q_lo, r_lo} = fix_div(s4_y, s4_m);
    t_full   = {s4_qhi, q_lo[CW-1:0]};
    use_term = {1'b0, series_terms} >= K_V;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.ctl <= '0;
      s2.ctl <= '0;
      s3.ctl <= '0;
      s4.ctl <= '0;
      s5.ctl <= '0;
      s6.ctl <= '0;
      ctl_out <= '0;
    end else if (en) begin
      s1.ctl <= pass_in.ctl;
      s2.ctl <= s1.ctl;
      s3.ctl <= s2.ctl;
      s4.ctl <= s3.ctl;
      s5.ctl <= s4.ctl;
      s6.ctl <= s5.ctl;
      ctl_out <= s6.ctl;
    end

    if (en) begin
      s1.x <= pass_in.x;  s1.sum <= pass_in.sum;
      s2.x <= s1.x;       s2.sum <= s1.sum;
      s3.x <= s2.x;       s3.sum <= s2.sum;
      s4.x <= s3.x;       s4.sum <= s3.sum;
      s5.x <= s4.x;       s5.sum <= s4.sum;
      s6.x <= s5.x;       s6.sum <= s5.sum;
      x_out <= s6.x;

      s1_p   <= tx[kwc_pkg::T_SHIFT +: kwc_pkg::P_W];
      s2_y   <= y_hi;
      s2_m   <= y_hi * RECIP;
      s2_lo  <= s1_p[CW-1:0];
      s3_q   <= q_hi[CW-1:0];
      s3_r   <= r_hi[R_W-1:0];
      s2_lo_q <= s2_lo;
      s4_qhi <= s3_q;
      s4_y   <= y_lo;
      s4_m   <= y_lo * RECIP;
      s5_t   <= t_full[kwc_pkg::T_W-1:0];
      s6_t   <= s5_t;
      s6_sq  <= s5_t[kwc_pkg::T_W-1:kwc_pkg::H_SHIFT] * s5_t[kwc_pkg::T_W-1:kwc_pkg::H_SHIFT];
      t_out  <= s6_t;
      sum_out <= use_term ? (s6.sum + kwc_pkg::SUM_W'(s6_sq)) : s6.sum;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kwc_back.sv =====
// Back end: sum times 1/I0(beta) as four partial products, saturation, output register and skid.
// Depends on kwc_pkg and the assertion header.
`default_nettype none
`include "kaiser_window_coefficient_unit_assert.svh"
module kwc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  kwc_pkg::kwc_ctl_t             ctl_in,
  input  logic [kwc_pkg::SUM_W-1:0]     sum_in,
  input  logic [kwc_pkg::INV_I0_W-1:0]  inv_i0_beta,
  input  logic                          out_ready,
  output logic                          en,
  output logic                          out_valid,
  output logic [kwc_pkg::COEF_W-1:0]    coefficient
);

  localparam int SL_W = 26;
  localparam int SH_W = kwc_pkg::SUM_W - SL_W;
  localparam int IL_W = 21;
  localparam int IH_W = kwc_pkg::INV_I0_W - IL_W;
  localparam int PP_W = SL_W + kwc_pkg::INV_I0_W + 1;
  localparam int PW   = kwc_pkg::PROD_W;
  localparam int UP_W = PW - kwc_pkg::RESULT_SHIFT;

  kwc_pkg::kwc_ctl_t f1_ctl, f2_ctl, f3_ctl;
  logic [SL_W+IL_W-1:0] p00;
  logic [SL_W+IH_W-1:0] p01;
  logic [SH_W+IL_W-1:0] p10;
  logic [SH_W+IH_W-1:0] p11;
  logic [PP_W-1:0]      f2_a, f2_b;
  logic [PW-1:0]        f3_prod;
  logic [UP_W-1:0]      upper;
  logic [kwc_pkg::COEF_W-1:0] coef_c, skid_data;
  logic                 skid_valid, push;

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_ctl <= '0;
      f2_ctl <= '0;
      f3_ctl <= '0;
    end else if (en) begin
      f1_ctl <= ctl_in;
      f2_ctl <= f1_ctl;
      f3_ctl <= f2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= sum_in[SL_W-1:0] * inv_i0_beta[IL_W-1:0];
      p01 <= sum_in[SL_W-1:0] * inv_i0_beta[kwc_pkg::INV_I0_W-1:IL_W];
      p10 <= sum_in[kwc_pkg::SUM_W-1:SL_W] * inv_i0_beta[IL_W-1:0];
      p11 <= sum_in[kwc_pkg::SUM_W-1:SL_W] * inv_i0_beta[kwc_pkg::INV_I0_W-1:IL_W];
      f2_a <= PP_W'(p00) + (PP_W'(p01) << IL_W);
      f2_b <= PP_W'(p10) + (PP_W'(p11) << IL_W);
      f3_prod <= PW'(f2_a) + (PW'(f2_b) << SL_W);
    end
  end

  always_comb begin
    upper = f3_prod[PW-1:kwc_pkg::RESULT_SHIFT];
    if (f3_ctl.zero) begin
      coef_c = '0;
    end else if (|upper[UP_W-1:kwc_pkg::COEF_W]) begin
      coef_c = kwc_pkg::COEF_MAX;
    end else begin
      coef_c = upper[kwc_pkg::COEF_W-1:0];
    end
    push = f3_ctl.valid && en;
  end

  // A word that arrives while the output is held goes to the skid register,
  // which then stalls the pipeline until the output is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (push) begin
        skid_data <= coef_c;
      end
    end else if (skid_valid) begin
      coefficient <= skid_data;
    end else if (push) begin
      coefficient <= coef_c;
    end
  end

  `KWC_ASSERT_RST(a_reset_clears, rst |=> !out_valid && !skid_valid)
  `KWC_ASSERT(a_skid_behind_out, skid_valid |-> out_valid)
  `KWC_ASSERT(a_skid_fills_on_stall, $rose(skid_valid) |-> $past(out_valid && !out_ready))
  `KWC_ASSERT(a_skid_drains_on_take, $fell(skid_valid) |-> $past(out_ready))

endmodule
`default_nettype wire

// ===== rtl/core/kaiser_window_coefficient_unit.sv =====
// Kaiser window coefficient unit: one coefficient word per index word, fully pipelined.
// Register stages: 2 front stages, 26 for the bit-per-stage square root and beta scaling, 7 per
// series term, 3 for the final scaling and 1 output register. Throughput: one word per cycle
// while the output is taken; a held output stalls the input until the word in the skid register
// has moved to the output.
// Reset clears every valid bit and loads the registers with their documented defaults.
`default_nettype none
module kaiser_window_coefficient_unit #(
  parameter int MAX_LENGTH = kwc_pkg::MAX_LENGTH_DEF,
  parameter int MAX_TERMS  = kwc_pkg::MAX_TERMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kwc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kwc_pkg::IDX_W-1:0]       sample_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kwc_pkg::COEF_W-1:0]      coefficient
);

  logic [kwc_pkg::LEN_W-1:0]     window_length;
  logic [kwc_pkg::INV_LEN_W-1:0] inv_length_minus_one;
  logic [kwc_pkg::BETA_W-1:0]    kaiser_beta;
  logic [kwc_pkg::INV_I0_W-1:0]  inv_i0_beta;
  logic [kwc_pkg::TERMS_W-1:0]   series_terms;
  logic                          en;

  assign cfg_ready = 1'b1;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length        <= kwc_pkg::RST_WINDOW_LENGTH;
      inv_length_minus_one <= kwc_pkg::RST_INV_LENGTH;
      kaiser_beta          <= kwc_pkg::RST_BETA;
      inv_i0_beta          <= kwc_pkg::RST_INV_I0;
      series_terms         <= kwc_pkg::RST_TERMS;
    end else if (cfg_valid) begin
      case (kwc_pkg::cfg_reg_t'(cfg_index))
        kwc_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[kwc_pkg::LEN_W-1:0];
        kwc_pkg::REG_INV_LENGTH:    inv_length_minus_one <= cfg_data[kwc_pkg::INV_LEN_W-1:0];
        kwc_pkg::REG_KAISER_BETA:   kaiser_beta <= cfg_data[kwc_pkg::BETA_W-1:0];
        kwc_pkg::REG_INV_I0_BETA:   inv_i0_beta <= cfg_data[kwc_pkg::INV_I0_W-1:0];
        kwc_pkg::REG_SERIES_TERMS:  series_terms <= cfg_data[kwc_pkg::TERMS_W-1:0];
        default: ;
      endcase
    end
  end

  kwc_pkg::kwc_ctl_t          f_ctl;
  logic [kwc_pkg::V_W-1:0]    f_v;
  kwc_pkg::kwc_ctl_t          tc [MAX_TERMS+1];
  logic [kwc_pkg::X_W-1:0]    tx [MAX_TERMS+1];
  logic [kwc_pkg::T_W-1:0]    tt [MAX_TERMS+1];
  logic [kwc_pkg::SUM_W-1:0]  ts [MAX_TERMS+1];

  kwc_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .sample_index(sample_index),
    .window_length(window_length), .inv_length_minus_one(inv_length_minus_one),
    .ctl_out(f_ctl), .v_out(f_v)
  );

  kwc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .ctl_in(f_ctl), .v_in(f_v),
    .kaiser_beta(kaiser_beta), .ctl_out(tc[0]), .x_out(tx[0])
  );

  assign tt[0] = kwc_pkg::ONE_T;
  assign ts[0] = kwc_pkg::ONE_SUM;

  for (genvar k = 1; k <= MAX_TERMS; k++) begin : g_term
    kwc_term #(.K(k), .MAX_TERMS(MAX_TERMS)) u_term (
      .clk(clk), .rst(rst), .en(en), .series_terms(series_terms),
      .ctl_in(tc[k-1]), .x_in(tx[k-1]), .t_in(tt[k-1]), .sum_in(ts[k-1]),
      .ctl_out(tc[k]), .x_out(tx[k]), .t_out(tt[k]), .sum_out(ts[k])
    );
  end

  kwc_back u_back (
    .clk(clk), .rst(rst), .ctl_in(tc[MAX_TERMS]), .sum_in(ts[MAX_TERMS]),
    .inv_i0_beta(inv_i0_beta), .out_ready(out_ready), .en(en),
    .out_valid(out_valid), .coefficient(coefficient)
  );

endmodule
`default_nettype wire

// ===== tb/kaiser_window_coefficient_unit_tb.sv =====
// Self-checking testbench for the Kaiser window coefficient unit.
// Depends on kwc_pkg and the RTL only. It predicts each coefficient word in fixed point
// and checks results in order while both handshakes idle and stall at random.
`default_nettype none
module kaiser_window_coefficient_unit_tb;

  localparam logic [kwc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd6;  // decodes to no register

  logic                           clk;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [kwc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kwc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [kwc_pkg::IDX_W-1:0]      sample_index;
  logic                           out_valid;
  logic                           out_ready;
  logic [kwc_pkg::COEF_W-1:0]     coefficient;

  kaiser_window_coefficient_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample_index(sample_index),
    .out_valid(out_valid), .out_ready(out_ready), .coefficient(coefficient)
  );

  // Shadow copy of the configuration registers.
  logic [kwc_pkg::LEN_W-1:0]     win_len;
  logic [kwc_pkg::INV_LEN_W-1:0] inv_len;
  logic [kwc_pkg::BETA_W-1:0]    beta;
  logic [kwc_pkg::INV_I0_W-1:0]  inv_i0;
  logic [kwc_pkg::TERMS_W-1:0]   n_terms;

  logic [kwc_pkg::COEF_W-1:0] coef_q[$];
  int errors;
  int burst_left;
  bit gaps_on;
  int stall_mode;
  bit hold_req;
  int hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[kaiser_window_coefficient_unit] ERROR");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [kwc_pkg::COEF_W-1:0] kaiser_coef(logic [kwc_pkg::IDX_W-1:0] n);
    longint       len;
    longint       d;
    logic [63:0]  a, r2, root, x, t, h, sum, terms;
    logic [127:0] prod;
    len = (win_len > 1024) ? 1024 : win_len;
    if (n >= len) return '0;
    d = 2 * longint'(n) - (len - 1);
    if (d < 0) d = -d;
    a = 64'(d) * inv_len;
    r2 = (a >= (64'd1 << 24)) ? (64'd1 << 24) : ((a * a) >> 24);
    root = int_sqrt(((64'd1 << 24) - r2) << 24);
    x = (64'(beta) * root) >> 24;
    terms = (n_terms > 32) ? 32 : n_terms;
    t = 64'd1 << 30;
    sum = 64'd1 << 30;
    for (int k = 1; k <= terms; k++) begin
      t = ((t * x) >> 20) / (2 * k);
      h = t >> 15;
      sum = sum + h * h;
    end
    prod = (128'(sum) * inv_i0) >> 47;
    return (prod > 128'hFFFFFF) ? kwc_pkg::COEF_MAX : prod[kwc_pkg::COEF_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Checks every coefficient word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (coef_q.size() == 0) report_mismatch("unexpected word", coefficient, 0);
      else begin
        logic [kwc_pkg::COEF_W-1:0] want;
        want = coef_q.pop_front();
        if (coefficient !== want) report_mismatch("coefficient", coefficient, want);
      end
    end
  end

  // Receiver stalls on its own pattern; a hold request keeps it off for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt <= 600;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (stall_mode == 0) begin
      out_ready <= 1'b1;
    end else if (stall_mode == 1) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_index(logic [kwc_pkg::IDX_W-1:0] n);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample_index <= n;
    do @(posedge clk); while (!in_ready);
    coef_q.push_back(kaiser_coef(n));
  endtask

  // Sender pauses until the pipeline has drained; every index yields one word.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (coef_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [kwc_pkg::CFG_IDX_W-1:0] idx,
                           logic [kwc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      kwc_pkg::REG_WINDOW_LENGTH: win_len = val[kwc_pkg::LEN_W-1:0];
      kwc_pkg::REG_INV_LENGTH:    inv_len = val[kwc_pkg::INV_LEN_W-1:0];
      kwc_pkg::REG_KAISER_BETA:   beta = val[kwc_pkg::BETA_W-1:0];
      kwc_pkg::REG_INV_I0_BETA:   inv_i0 = val[kwc_pkg::INV_I0_W-1:0];
      kwc_pkg::REG_SERIES_TERMS:  n_terms = val[kwc_pkg::TERMS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_window(int len, int b, logic [40:0] i0, int k);
    write_reg(kwc_pkg::REG_WINDOW_LENGTH, len);
    write_reg(kwc_pkg::REG_INV_LENGTH,
              (len > 1) ? ((64'd1 << 24) / (len - 1)) : (64'd1 << 24));
    write_reg(kwc_pkg::REG_KAISER_BETA, b);
    write_reg(kwc_pkg::REG_INV_I0_BETA, i0);
    write_reg(kwc_pkg::REG_SERIES_TERMS, k);
  endtask

  task automatic test_reset_defaults();
    logic [kwc_pkg::IDX_W-1:0] pts[7] = '{0, 1, 23, 24, 47, 48, 1023};
    foreach (pts[i]) send_index(pts[i]);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    set_window(2, 24'hFFFFFF, 41'h100_0000_0000, 32);
    send_index(0); send_index(1); send_index(2);
    wait_drained();
    set_window(1024, 0, 41'h1FF_FFFF_FFFF, 1);
    send_index(0); send_index(511); send_index(1023);
    wait_drained();
    // Lengths above the limit behave as the largest length; term counts likewise.
    write_reg(kwc_pkg::REG_WINDOW_LENGTH, 11'h7FF);
    write_reg(kwc_pkg::REG_SERIES_TERMS, 6'h3F);
    write_reg(kwc_pkg::REG_KAISER_BETA, 24'hFFFFFF);
    send_index(1023); send_index(512); send_index(700);
    wait_drained();
    write_reg(kwc_pkg::REG_SERIES_TERMS, 0);
    write_reg(kwc_pkg::REG_WINDOW_LENGTH, 0);
    send_index(0); send_index(5);
    wait_drained();
    write_reg(kwc_pkg::REG_WINDOW_LENGTH, 1);
    write_reg(kwc_pkg::REG_INV_LENGTH, 16400);
    write_reg(kwc_pkg::REG_SERIES_TERMS, 20);
    send_index(0); send_index(1);
    wait_drained();
    // A write to an index with no register must change nothing.
    write_reg(REG_SPARE, '1);
    send_index(0); send_index(682);
    wait_drained();
  endtask

  task automatic test_output_holdoff();
    set_window(64, 8238934, 41'd2940000000, 15);
    hold_req = 1'b1;
    gaps_on = 1'b0;
    repeat (320) send_index($urandom_range(0, 70));
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_windows();
    int len;
    for (int ph = 0; ph < 8; ph++) begin
      len = (ph == 0) ? 1024 : (ph == 1) ? 2 : $urandom_range(2, 1024);
      set_window(len, $urandom_range(0, 24'hFFFFFF),
                 {$urandom_range(0, 1), $urandom, 8'($urandom)} >> $urandom_range(0, 2),
                 $urandom_range(1, 32));
      if (ph == 7) begin
        write_reg(kwc_pkg::REG_INV_LENGTH, $urandom_range(16400, 25'h1000000));
        write_reg(kwc_pkg::REG_INV_I0_BETA, $urandom_range(0, 32'hFFFFFFFF));
      end
      stall_mode = ph % 3;
      gaps_on = (ph % 4) != 3;
      for (int i = 0; i < 45; i++)
        send_index(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, len - 1));
      wait_drained();
    end
    stall_mode = 1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_index = '0;
    errors = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    stall_mode = 1;
    hold_req = 1'b0;
    win_len = kwc_pkg::RST_WINDOW_LENGTH;
    inv_len = kwc_pkg::RST_INV_LENGTH;
    beta = kwc_pkg::RST_BETA;
    inv_i0 = kwc_pkg::RST_INV_I0;
    n_terms = kwc_pkg::RST_TERMS;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_output_holdoff();
    test_random_windows();
    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("[kaiser_window_coefficient_unit] OK");
    else $display("[kaiser_window_coefficient_unit] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
